@@ design/amid_pkg.sv @@
// Shared types, constants and helpers for the accelerometer motion/idle detector.
package amid_pkg;

  // Ring depth and derived widths
  localparam int HISTORY_DEPTH = 5;
  localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 2);
  localparam int AXIS_W        = 16;
  localparam int SAMPLE_W      = 3 * AXIS_W;

  // Request kinds carried on s_tuser
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_STOP   = 2'd2;

  // Configuration register indexes
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic [15:0] THRESHOLD_RESET = 16'd2;

  // Motion state codes; invalid is internal only
  typedef enum logic [1:0] {
    MS_UNKNOWN  = 2'd0,
    MS_MOVEMENT = 2'd1,
    MS_IDLE     = 2'd2,
    MS_INVALID  = 2'd3
  } motion_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_WAIT,
    ST_DECODE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic start;
    logic stop;
    logic store;
    logic scan;
    logic decide;
    logic push;
  } amid_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       enabled;
    logic       scan_last;
    logic       has_result;
    logic       out_free;
  } amid_status_t;

  // Previous ring slot, wrapping at the bottom
  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == '0) begin
      r = SLOT_W'(HISTORY_DEPTH - 1);
    end else begin
      r = s - 1'b1;
    end
    return r;
  endfunction

endpackage

@@ design/amid_ctrl.sv @@
// Sequencing state machine for the motion/idle detector.
module amid_ctrl
  import amid_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  amid_status_t status,
  output amid_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WAIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_WAIT: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_WAIT;
        case (status.op)
          OP_START: begin
            if (!status.enabled) begin
              cmd.start  = 1'b1;
              state_next = ST_EMIT;
            end
          end
          OP_STOP: begin
            cmd.stop = 1'b1;
          end
          OP_SAMPLE: begin
            if (status.enabled) begin
              cmd.store  = 1'b1;
              state_next = ST_SCAN;
            end
          end
          default: begin
            state_next = ST_WAIT;
          end
        endcase
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = status.has_result ? ST_EMIT : ST_WAIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_WAIT;
        end
      end
      default: begin
        state_next = ST_WAIT;
      end
    endcase
  end

endmodule

@@ design/amid_datapath.sv @@
// Sample ring, comparison unit, motion state and output register.
module amid_datapath
  import amid_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  amid_cmd_t     cmd,
  output amid_status_t  status,
  input  logic [15:0]   threshold,
  input  logic [1:0]    in_op,
  input  logic [47:0]   in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_state
);

  // Captured request
  logic [1:0]          op;
  logic [SAMPLE_W-1:0] newest;

  // Ring memory and read port
  logic [SAMPLE_W-1:0] ring [HISTORY_DEPTH];
  logic [SAMPLE_W-1:0] rd_data;
  logic [SLOT_W-1:0]   rd_slot;
  logic [SLOT_W-1:0]   rd_addr;

  // Control state
  logic [SLOT_W-1:0]   write_slot;
  logic [CNT_W-1:0]    held_count;
  motion_t             motion_state;
  logic                enabled;
  logic [SLOT_W-1:0]   scan_j;
  logic                prev_diff;
  logic                any_diff;
  motion_t             res_state;

  logic                far;
  logic                go_move;
  logic                go_idle;

  // |a - b| >= thr on one axis
  function automatic logic axis_far(input logic [15:0] a, input logic [15:0] b,
                                    input logic [15:0] thr);
    logic [16:0] d;
    logic [16:0] mag;
    d   = {a[15], a} - {b[15], b};
    mag = d[16] ? (17'd0 - d) : d;
    return mag >= {1'b0, thr};
  endfunction

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= in_op;
      newest <= in_data;
    end
  end

  // Ring write and registered read
  assign rd_addr = cmd.store ? slot_dec(write_slot) : slot_dec(rd_slot);

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      ring[write_slot] <= newest;
    end
    if (cmd.store || cmd.scan) begin
      rd_data <= ring[rd_addr];
      rd_slot <= rd_addr;
    end
  end

  // Compare newest against the sample just read
  assign far = axis_far(newest[15:0],  rd_data[15:0],  threshold) ||
               axis_far(newest[31:16], rd_data[31:16], threshold) ||
               axis_far(newest[47:32], rd_data[47:32], threshold);

  // Scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      scan_j    <= SLOT_W'(1);
      any_diff  <= 1'b0;
      prev_diff <= 1'b0;
    end else if (cmd.scan) begin
      scan_j   <= scan_j + 1'b1;
      any_diff <= any_diff | far;
      if (scan_j == SLOT_W'(1)) begin
        prev_diff <= far;
      end
    end
  end

  // Decision on the finished scan
  assign go_move = (held_count >= CNT_W'(2)) && prev_diff && (motion_state != MS_MOVEMENT);
  assign go_idle = !go_move && (held_count >= CNT_W'(HISTORY_DEPTH + 1)) && !any_diff &&
                   (motion_state != MS_IDLE);

  // Block state
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled      <= 1'b0;
      held_count   <= '0;
      write_slot   <= '0;
      motion_state <= MS_INVALID;
    end else begin
      if (cmd.start) begin
        enabled <= 1'b1;
      end
      if (cmd.stop) begin
        enabled      <= 1'b0;
        held_count   <= '0;
        write_slot   <= '0;
        motion_state <= MS_INVALID;
      end
      if (cmd.store) begin
        write_slot <= (write_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : write_slot + 1'b1;
        if (held_count != CNT_W'(HISTORY_DEPTH + 1)) begin
          held_count <= held_count + 1'b1;
        end
      end
      if (cmd.decide) begin
        if (go_move) begin
          motion_state <= MS_MOVEMENT;
        end else if (go_idle) begin
          motion_state <= MS_IDLE;
        end
      end
    end
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      res_state <= MS_UNKNOWN;
    end else if (cmd.decide) begin
      res_state <= go_move ? MS_MOVEMENT : MS_IDLE;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_state <= res_state;
    end
  end

  // Status back to the controller
  always_comb begin
    status.op         = op;
    status.enabled    = enabled;
    status.scan_last  = (scan_j == SLOT_W'(HISTORY_DEPTH - 1));
    status.has_result = go_move || go_idle;
    status.out_free   = !out_valid || out_ready;
  end

  // Checks
  a_held_sat: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(HISTORY_DEPTH + 1))
    else $error("held count beyond saturation");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    write_slot < SLOT_W'(HISTORY_DEPTH))
    else $error("write slot out of range");

  a_out_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_state != MS_INVALID)
    else $error("invalid state presented");

  a_disabled_clear: assert property (@(posedge clk) disable iff (rst)
    !enabled |-> (held_count == '0 && write_slot == '0))
    else $error("history kept while disabled");

  a_decide_state: assert property (@(posedge clk) disable iff (rst)
    (cmd.decide && status.has_result) |=> motion_state == res_state)
    else $error("reported state differs from held state");

endmodule

@@ design/accel_motion_idle_detector_core.sv @@
// Top level: stream ports, APB threshold register, controller and datapath.
// A sample request is stored, the ring is then scanned through its single read port, and a
// decision follows; a reported state is emitted before the next request is accepted, so no
// new request is taken until the last one is done. A start request emits an unknown state;
// a stop or ignored request emits nothing; a result not yet taken stalls.
// Synchronous active-high reset: disabled, empty history, threshold 2, no output.
module accel_motion_idle_detector_core
  import amid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // new_state[1:0], zero fill[7:2]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  amid_cmd_t    cmd;
  amid_status_t status;
  logic [15:0]  threshold;
  logic [1:0]   out_state;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_THRESHOLD) begin
      threshold <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_THRESHOLD) ? {16'd0, threshold} : 32'd0;

  amid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  amid_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .threshold (threshold),
    .in_op     (s_tuser),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_state (out_state)
  );

  assign m_tdata = {6'd0, out_state};

endmodule

@@ tb/accel_motion_idle_detector_core_test.sv @@
// Testbench for the accelerometer motion/idle detector: stream stimulus, APB threshold, scoreboard.
`timescale 1ns / 100ps

module accel_motion_idle_detector_core_test;
  import amid_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASES = 6;

  // Predicts reported motion states and holds them until the block emits them
  class motion_scoreboard;
    logic [15:0]        threshold;
    logic signed [15:0] ring [HISTORY_DEPTH][3];
    int                 wslot;
    int                 held;
    motion_t            mstate;
    bit                 enabled;
    motion_t            expected_q[$];
    int                 errors;

    function new();
      threshold = THRESHOLD_RESET;
      wslot     = 0;
      held      = 0;
      mstate    = MS_INVALID;
      enabled   = 1'b0;
      errors    = 0;
    endfunction

    function void set_threshold(logic [15:0] v);
      threshold = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Any axis of the newest sample at least threshold away from the one back steps earlier
    function bit differs_from(int back);
      int newest;
      int older;
      int d;
      int i;
      bit hit;
      hit    = 1'b0;
      newest = (wslot + HISTORY_DEPTH - 1) % HISTORY_DEPTH;
      older  = (newest + HISTORY_DEPTH - back) % HISTORY_DEPTH;
      for (i = 0; i < 3; i++) begin
        d = int'(ring[newest][i]) - int'(ring[older][i]);
        if (d < 0) d = -d;
        if (d >= int'(threshold)) hit = 1'b1;
      end
      return hit;
    endfunction

    // Note an accepted request; returns 1 if the block acts on it
    function bit note_request(logic [1:0] op, logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
      bit quiet;
      int j;
      case (op)
        OP_START: begin
          if (enabled) return 1'b0;
          enabled = 1'b1;
          expected_q.push_back(MS_UNKNOWN);
          return 1'b1;
        end
        OP_STOP: begin
          enabled = 1'b0;
          held    = 0;
          wslot   = 0;
          mstate  = MS_INVALID;
          return 1'b1;
        end
        OP_SAMPLE: begin
          if (!enabled) return 1'b0;
          ring[wslot][0] = x;
          ring[wslot][1] = y;
          ring[wslot][2] = z;
          wslot = (wslot + 1) % HISTORY_DEPTH;
          if (held < HISTORY_DEPTH + 1) held++;
          if (held >= 2 && differs_from(1) && mstate != MS_MOVEMENT) begin
            mstate = MS_MOVEMENT;
            expected_q.push_back(MS_MOVEMENT);
          end else if (held >= HISTORY_DEPTH + 1) begin
            quiet = 1'b1;
            for (j = 1; j < HISTORY_DEPTH; j++) begin
              if (differs_from(j)) quiet = 1'b0;
            end
            if (quiet && mstate != MS_IDLE) begin
              mstate = MS_IDLE;
              expected_q.push_back(MS_IDLE);
            end
          end
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    // Compare one emitted result with the oldest expectation
    function void check_result(logic [7:0] data);
      motion_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual new_state %0d (tdata %h)",
                 $time, data[1:0], data);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (data !== {6'b0, want}) begin
          $display("%0t: new_state mismatch, expected %h actual %h", $time, {6'b0, want}, data);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  logic [1:0]  s_tuser = '0;   // op[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // new_state[1:0], zero fill[7:2]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  motion_scoreboard sb;
  int tx_idle_pct = 37;
  int rx_idle_pct = 68;
  int hold_left = 0;
  logic [15:0] phase_threshold [PHASES];
  int tx_plan [PHASES] = '{37, 37, 68, 68, 0, 0};
  int rx_plan [PHASES] = '{68, 68, 37, 37, 0, 0};

  accel_motion_idle_detector_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Receiver: random stalls, or a long hold-off counted here
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Offer one request, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_request(input logic [1:0] op, input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z, output bit acted);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {z, y, x};
    do @(posedge clk); while (!s_tready);
    acted = sb.note_request(op, x, y, z);
  endtask

  // Stop offering and wait until every expected result has come, then let the block settle
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the movement threshold
  task automatic write_threshold(input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_THRESHOLD);
    pwdata  <= {16'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_threshold(v);
  endtask

  function automatic logic [15:0] quiet_axis(int b, int s);
    return 16'(b + int'($urandom_range(s)));
  endfunction

  // Start, a burst of samples around a level with occasional jumps, sometimes a stop
  task automatic run_random(input int target);
    int done;
    int thr;
    int spread;
    int len;
    int k;
    int lvl [3];
    bit acted;
    done = 0;
    thr  = int'(sb.threshold);
    while (done < target) begin
      if ($urandom_range(99) < 10) begin
        send_request(2'($urandom_range(3)), 16'($urandom), 16'($urandom), 16'($urandom), acted);
        done += acted;
      end else begin
        send_request(OP_START, 16'($urandom), 16'($urandom), 16'($urandom), acted);
        done += acted;
        // mostly just under threshold, sometimes right at it
        spread = ($urandom_range(99) < 75) ? ((thr == 0) ? 0 : thr - 1) : thr;
        for (k = 0; k < 3; k++) lvl[k] = -32768 + int'($urandom_range(65535 - spread));
        len = $urandom_range(1, 20);
        repeat (len) begin
          if ($urandom_range(99) < 12) begin
            send_request(OP_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom), acted);
          end else begin
            send_request(OP_SAMPLE, quiet_axis(lvl[0], spread), quiet_axis(lvl[1], spread),
                         quiet_axis(lvl[2], spread), acted);
          end
          done += acted;
        end
        if ($urandom_range(99) < 40) begin
          send_request(OP_STOP, 16'($urandom), 16'($urandom), 16'($urandom), acted);
          done += acted;
        end
      end
    end
  endtask

  // Main sequence
  initial begin
    int p;
    bit acted;
    sb = new();
    phase_threshold[0] = 16'd2;
    phase_threshold[1] = 16'd0;
    phase_threshold[2] = 16'hffff;
    phase_threshold[3] = 16'($urandom_range(1, 40));
    phase_threshold[4] = 16'($urandom_range(41, 2000));
    phase_threshold[5] = 16'd1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: ignored requests, double start, idle, movement, full-scale swings
    send_request(OP_SAMPLE, 16'h7fff, 16'h8000, 16'hffff, acted);
    send_request(OP_UNUSED, 16'h0000, 16'h0000, 16'h0000, acted);
    send_request(OP_STOP, 16'h0000, 16'h0000, 16'h0000, acted);
    send_request(OP_START, 16'h0000, 16'h0000, 16'h0000, acted);
    send_request(OP_START, 16'hffff, 16'hffff, 16'hffff, acted);
    send_request(OP_SAMPLE, 16'd0, 16'd0, 16'd0, acted);
    repeat (5) send_request(OP_SAMPLE, 16'd1, 16'd1, 16'd1, acted);
    send_request(OP_SAMPLE, 16'h8000, 16'h7fff, 16'h0000, acted);
    send_request(OP_SAMPLE, 16'h8000, 16'h7fff, 16'h0000, acted);
    send_request(OP_STOP, 16'h0000, 16'h0000, 16'h0000, acted);
    send_request(OP_START, 16'h0000, 16'h0000, 16'h0000, acted);
    send_request(OP_SAMPLE, 16'h7fff, 16'h8000, 16'hffff, acted);
    send_request(OP_SAMPLE, 16'h8000, 16'h7fff, 16'h0000, acted);
    wait_for_results();

    for (p = 0; p < PHASES; p++) begin
      tx_idle_pct = tx_plan[p];
      rx_idle_pct = rx_plan[p];
      write_threshold(phase_threshold[p]);

      // Extreme thresholds: zero flags every sample, even an unchanged one, full scale needs a rail-to-rail swing
      if (phase_threshold[p] == 16'd0) begin
        send_request(OP_STOP, 16'h0000, 16'h0000, 16'h0000, acted);
        send_request(OP_START, 16'h0000, 16'h0000, 16'h0000, acted);
        send_request(OP_SAMPLE, 16'd5, 16'd5, 16'd5, acted);
        send_request(OP_SAMPLE, 16'd5, 16'd5, 16'd5, acted);
      end
      if (phase_threshold[p] == 16'hffff) begin
        send_request(OP_STOP, 16'h0000, 16'h0000, 16'h0000, acted);
        send_request(OP_START, 16'h0000, 16'h0000, 16'h0000, acted);
        send_request(OP_SAMPLE, 16'h7fff, 16'h0000, 16'h0000, acted);
        send_request(OP_SAMPLE, 16'h8000, 16'h0000, 16'h0000, acted);
        send_request(OP_SAMPLE, 16'h8000, 16'h0001, 16'h0000, acted);
      end

      // Long receiver hold-off while start/stop pairs keep results coming
      if (p == 2) begin
        hold_left = 400;
        repeat (12) begin
          send_request(OP_START, 16'($urandom), 16'($urandom), 16'($urandom), acted);
          send_request(OP_STOP, 16'($urandom), 16'($urandom), 16'($urandom), acted);
        end
      end

      run_random(100);
      if (p == 1) wait_for_results();
      run_random(100);
      wait_for_results();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS accel_motion_idle_detector_core");
    end else begin
      $display("FAIL accel_motion_idle_detector_core");
    end
    $finish;
  end

  // Run limit
  initial begin
    #4_000_000;
    $display("FAIL accel_motion_idle_detector_core");
    $finish;
  end

endmodule

@@ files.f @@
design/amid_pkg.sv
design/amid_ctrl.sv
design/amid_datapath.sv
design/accel_motion_idle_detector_core.sv
tb/accel_motion_idle_detector_core_test.sv
